FILE: rtl/rssd_pkg.sv
package rssd_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int COORD_BITS = 16;

  localparam logic [7:0] OP_NEW_ROW = 8'h00;
  localparam logic [7:0] OP_END = 8'h80;
  localparam logic [7:0] OP_SHADOW = 8'hC0;
  localparam logic [7:0] OP_REPEAT = 8'hC1;
  localparam logic [31:0] SHADOW_ARGB = 32'h4000_0000;
  localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;

  // configuration register indexes
  localparam logic CFG_DECODE_MODE = 1'b0;
  localparam logic CFG_MONO_COLOR = 1'b1;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_END_SEEN = 2'd1,
    ST_RAN_OUT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CSEL_NONE,
    CSEL_PALETTE,
    CSEL_SHADOW
  } color_sel_t;

  typedef struct packed {
    logic req_type;
    logic [7:0] data_byte;
    logic last_byte;
    logic [7:0] pal_index;
    logic [23:0] pal_rgb;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] span_x;
    logic [15:0] span_row;
    logic [7:0] span_len;
    logic [31:0] pixel_argb;
    logic [1:0] status;
  } out_beat_t;

  // decoded span waiting for its palette read
  typedef struct packed {
    logic [15:0] span_x;
    logic [15:0] span_row;
    logic [7:0] span_len;
    status_t status;
    color_sel_t csel;
    logic pal_oor;
  } span_stage_t;

endpackage

FILE: rtl/rle_sprite_span_decoder_top.sv
// a data beat's result is registered in the span stage s1, then in the output register out_data
// throughput: one beat per cycle (data or palette write) while s1 is not stalled; the one palette
//   read per data beat goes to the palette memory's single read port in the accept cycle
// reset: rst (synchronous) clears parser, cursors, end flag, pipeline valids and decode mode;
//   sets mono color index to 1; palette is not cleared and is undefined until written
module rle_sprite_span_decoder_top (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  rssd_pkg::in_beat_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rssd_pkg::out_beat_t out_data,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam logic [rssd_pkg::COORD_BITS-1:0] COORD_MAX = '1;

  typedef enum logic [2:0] {
    PH_OPCODE = 3'd0,
    PH_LITERAL = 3'd1,
    PH_SHADOW_SEL = 3'd2,
    PH_SHADOW_LEN = 3'd3,
    PH_REP_COUNT = 3'd4,
    PH_REP_COLOR = 3'd5
  } phase_t;

  // configuration
  logic decode_mode;
  logic [7:0] mono_color_index;

  // parser state
  phase_t phase, phase_next;
  logic [7:0] run_count, run_count_next;
  logic [rssd_pkg::COORD_BITS-1:0] cursor_x, cursor_x_next;
  logic [rssd_pkg::COORD_BITS-1:0] cursor_y, cursor_y_next;
  logic finished, finished_next;

  // palette memory, one write and one registered read per cycle
  logic [23:0] palette [rssd_pkg::PALETTE_DEPTH];
  logic [23:0] pal_rdata;

  // pipeline
  logic s1_valid;
  rssd_pkg::span_stage_t s1;
  logic s1_advance;

  logic accept, data_accept, wr_accept;
  logic wr_in_range;

  // decode signals
  logic span, is_end, emit, do_new_row;
  logic [7:0] len;
  logic [7:0] skip_amt;
  logic [7:0] add_amt;
  logic [7:0] rd_index;
  rssd_pkg::color_sel_t csel;
  logic [rssd_pkg::COORD_BITS:0] x_sum;
  logic [rssd_pkg::COORD_BITS-1:0] x_sat, x_after, y_after;
  logic [7:0] b;
  logic [7:0] count_dec;
  rssd_pkg::span_stage_t s1_in;

  // a new beat is taken whenever the span stage is empty or moves on
  assign s1_advance = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_advance;
  assign accept = in_valid && in_ready;
  assign data_accept = accept && !in_data.req_type;
  assign wr_accept = accept && in_data.req_type;
  assign wr_in_range = {1'b0, in_data.pal_index} < 9'(rssd_pkg::PALETTE_DEPTH);

  assign b = in_data.data_byte;
  assign count_dec = run_count - 8'd1;

  // opcode / operand decode, one byte per cycle while data beats are accepted
  always_comb begin
    phase_next = phase;
    run_count_next = run_count;
    finished_next = finished;
    span = 1'b0;
    is_end = 1'b0;
    do_new_row = 1'b0;
    len = '0;
    skip_amt = '0;
    rd_index = b;
    csel = rssd_pkg::CSEL_NONE;
    if (finished) begin
      // swallow bytes after the end marker
    end else if (decode_mode) begin
      phase_next = PH_OPCODE;
      if (b == rssd_pkg::OP_NEW_ROW) begin
        do_new_row = 1'b1;
      end else if (!b[7]) begin
        len = b;
        span = 1'b1;
        rd_index = mono_color_index;
        csel = rssd_pkg::CSEL_PALETTE;
      end else if (b == rssd_pkg::OP_END) begin
        is_end = 1'b1;
      end else begin
        skip_amt = {1'b0, b[6:0]};
      end
    end else begin
      case (phase)
        PH_LITERAL: begin
          len = 8'd1;
          span = 1'b1;
          csel = rssd_pkg::CSEL_PALETTE;
          run_count_next = count_dec;
          if (count_dec == 8'd0) phase_next = PH_OPCODE;
        end
        PH_SHADOW_SEL: begin
          if (b[1:0] != 2'd0) begin
            len = {6'd0, b[1:0]};
            span = 1'b1;
            csel = rssd_pkg::CSEL_SHADOW;
            phase_next = PH_OPCODE;
          end else begin
            phase_next = PH_SHADOW_LEN;
          end
        end
        PH_SHADOW_LEN: begin
          len = b;
          span = 1'b1;
          csel = rssd_pkg::CSEL_SHADOW;
          phase_next = PH_OPCODE;
        end
        PH_REP_COUNT: begin
          run_count_next = b;
          phase_next = PH_REP_COLOR;
        end
        PH_REP_COLOR: begin
          len = run_count;
          span = 1'b1;
          csel = rssd_pkg::CSEL_PALETTE;
          run_count_next = '0;
          phase_next = PH_OPCODE;
        end
        default: begin
          phase_next = PH_OPCODE;
          if (b == rssd_pkg::OP_NEW_ROW) begin
            do_new_row = 1'b1;
          end else if (!b[7]) begin
            run_count_next = b;
            phase_next = PH_LITERAL;
          end else if (b == rssd_pkg::OP_END) begin
            is_end = 1'b1;
          end else if (b < rssd_pkg::OP_SHADOW) begin
            skip_amt = {1'b0, b[6:0]};
          end else if (b == rssd_pkg::OP_SHADOW) begin
            phase_next = PH_SHADOW_SEL;
          end else if (b == rssd_pkg::OP_REPEAT) begin
            phase_next = PH_REP_COUNT;
          end else begin
            run_count_next = b - rssd_pkg::OP_SHADOW;
            phase_next = PH_REP_COLOR;
          end
        end
      endcase
    end
    // zero-length runs make no span
    if (len == 8'd0) span = 1'b0;
    if (!span) csel = rssd_pkg::CSEL_NONE;
    // end marker before the last byte: drop bytes until the last one
    if (is_end && !in_data.last_byte) finished_next = 1'b1;
  end

  // one saturating adder serves both skips and span advances
  assign add_amt = span ? len : skip_amt;
  assign x_sum = {1'b0, cursor_x} + (rssd_pkg::COORD_BITS + 1)'(add_amt);
  assign x_sat = x_sum[rssd_pkg::COORD_BITS] ? COORD_MAX : x_sum[rssd_pkg::COORD_BITS-1:0];
  assign x_after = do_new_row ? '0 : x_sat;
  assign y_after = (do_new_row && cursor_y != COORD_MAX) ?
                   cursor_y + (rssd_pkg::COORD_BITS)'(1) : cursor_y;

  assign emit = !finished && (span || is_end || in_data.last_byte);

  always_comb begin
    s1_in.span_x = 16'(span ? cursor_x : x_after);
    s1_in.span_row = 16'(y_after);
    s1_in.span_len = span ? len : 8'd0;
    s1_in.status = is_end ? rssd_pkg::ST_END_SEEN :
                   (in_data.last_byte ? rssd_pkg::ST_RAN_OUT : rssd_pkg::ST_NORMAL);
    s1_in.csel = csel;
    s1_in.pal_oor = {1'b0, rd_index} >= 9'(rssd_pkg::PALETTE_DEPTH);
    cursor_x_next = x_after;
    cursor_y_next = y_after;
  end

  // parser state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= 1'b0;
      mono_color_index <= 8'd1;
      phase <= PH_OPCODE;
      run_count <= '0;
      cursor_x <= '0;
      cursor_y <= '0;
      finished <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rssd_pkg::CFG_DECODE_MODE: decode_mode <= cfg_wdata[0];
          rssd_pkg::CFG_MONO_COLOR: mono_color_index <= cfg_wdata;
          default: ;
        endcase
      end
      if (data_accept) begin
        if (in_data.last_byte) begin
          // sprite done: ready for the next one, palette kept
          phase <= PH_OPCODE;
          run_count <= '0;
          cursor_x <= '0;
          cursor_y <= '0;
          finished <= 1'b0;
        end else begin
          phase <= phase_next;
          run_count <= run_count_next;
          cursor_x <= cursor_x_next;
          cursor_y <= cursor_y_next;
          finished <= finished_next;
        end
      end
    end
  end

  // palette memory: write on a palette beat, read on a data beat
  always_ff @(posedge clk) begin
    if (wr_accept && wr_in_range) begin
      palette[in_data.pal_index[rssd_pkg::PAL_AW-1:0]] <= in_data.pal_rgb;
    end
    if (data_accept) begin
      pal_rdata <= palette[rd_index[rssd_pkg::PAL_AW-1:0]];
    end
  end

  // span stage then output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_advance) begin
        out_valid <= s1_valid;
      end
      if (accept) begin
        s1_valid <= data_accept && emit;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (data_accept) s1 <= s1_in;
    if (s1_advance && s1_valid) begin
      out_data.span_x <= s1.span_x;
      out_data.span_row <= s1.span_row;
      out_data.span_len <= s1.span_len;
      out_data.status <= s1.status;
      case (s1.csel)
        rssd_pkg::CSEL_PALETTE:
          out_data.pixel_argb <= {rssd_pkg::OPAQUE_ALPHA, s1.pal_oor ? 24'd0 : pal_rdata};
        rssd_pkg::CSEL_SHADOW: out_data.pixel_argb <= rssd_pkg::SHADOW_ARGB;
        default: out_data.pixel_argb <= '0;
      endcase
    end
  end

  // while the end flag is set the parser sits in the opcode phase
  a_finished_opcode: assert property (@(posedge clk) disable iff (rst)
    finished |-> phase == PH_OPCODE)
    else $error("end flag set outside opcode phase");

  // literal phase always has bytes left
  a_literal_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LITERAL |-> run_count != 8'd0)
    else $error("literal phase with zero count");

  // a normal result always carries pixels
  a_span_len: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1.status == rssd_pkg::ST_NORMAL |-> s1.span_len != 8'd0)
    else $error("normal result without pixels");

  // a stalled span stage keeps its beat
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1))
    else $error("span stage lost a beat");

  // status results never carry a color
  a_status_color: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1.span_len == 8'd0 |-> s1.csel == rssd_pkg::CSEL_NONE)
    else $error("status result with color");

endmodule

FILE: sim/tb_top.sv
module tb_top;

  // run sizing
  localparam int unsigned RANDOM_BEATS = 260;
  localparam int unsigned DRAIN_CYCLES = 4;   // span stage and output register plus margin
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned STALL_LIMIT = 4000; // cycles with no beat on either side

  typedef logic [7:0] byte_seq_t[$];

  // parser position of the predictor
  typedef enum logic [2:0] {
    WANT_OP,
    WANT_LIT,
    WANT_SHD_SEL,
    WANT_SHD_LEN,
    WANT_REP_CNT,
    WANT_REP_IDX
  } parse_want_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  rssd_pkg::in_beat_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  rssd_pkg::out_beat_t out_data;
  logic cfg_we;
  logic cfg_index;
  logic [7:0] cfg_wdata;

  rle_sprite_span_decoder_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // span predictor: its own palette copy, parser and cursors
  // ---------------------------------------------------------------------
  logic [23:0] pal_ref [rssd_pkg::PALETTE_DEPTH];
  parse_want_t parse_st = WANT_OP;
  logic [7:0] run_left = '0;
  logic [rssd_pkg::COORD_BITS-1:0] cur_x = '0;
  logic [rssd_pkg::COORD_BITS-1:0] cur_y = '0;
  logic ended = 1'b0;       // end marker seen, skipping to the last byte
  logic mono_mode = 1'b0;   // decode_mode register
  logic [7:0] mono_idx = 8'd1;

  rssd_pkg::out_beat_t pending_spans[$];

  // bookkeeping for the summary
  int unsigned data_beats = 0;
  int unsigned pal_writes = 0;
  int unsigned live_beats = 0;   // beats the decoder actually acts on
  int unsigned cfg_writes = 0;
  int unsigned spans_seen = 0;
  int unsigned ends_seen = 0;
  int unsigned ranout_seen = 0;
  int unsigned fail_count = 0;

  // sender and receiver pacing
  int unsigned burst_left = 0;
  int unsigned ready_left = 0;
  int unsigned ready_style = 0;
  int unsigned quiet_cycles = 0;

  function automatic logic [31:0] opaque(input logic [7:0] idx);
    return {rssd_pkg::OPAQUE_ALPHA, pal_ref[idx]};
  endfunction

  function automatic void step_x(input logic [7:0] n);
    logic [rssd_pkg::COORD_BITS:0] sum;
    sum = {1'b0, cur_x} + {{(rssd_pkg::COORD_BITS-7){1'b0}}, n};
    cur_x = sum[rssd_pkg::COORD_BITS] ? '1 : sum[rssd_pkg::COORD_BITS-1:0];
  endfunction

  function automatic void next_row();
    cur_x = '0;
    if (cur_y != '1) cur_y = cur_y + 1'b1;
  endfunction

  function automatic void restart_sprite();
    parse_st = WANT_OP;
    run_left = '0;
    cur_x = '0;
    cur_y = '0;
    ended = 1'b0;
  endfunction

  // returns 1 when the beat produces a result, which is placed in span
  function automatic bit predict_span(input rssd_pkg::in_beat_t beat,
                                      output rssd_pkg::out_beat_t span);
    logic [7:0] d;
    logic [7:0] len;
    logic [31:0] argb;
    rssd_pkg::status_t st;
    bit drawn;
    span = '0;
    len = '0;
    argb = '0;
    st = rssd_pkg::ST_NORMAL;
    drawn = 1'b0;
    // palette writes never touch the parser
    if (beat.req_type) begin
      pal_ref[beat.pal_index] = beat.pal_rgb;
      return 1'b0;
    end
    d = beat.data_byte;
    // after the end marker everything up to the last byte is dropped
    if (ended) begin
      if (beat.last_byte) restart_sprite();
      return 1'b0;
    end
    if (mono_mode) begin
      // mono mode always reads an opcode
      parse_st = WANT_OP;
      if (d == rssd_pkg::OP_NEW_ROW) next_row();
      else if (d < rssd_pkg::OP_END) begin
        len = d;
        argb = opaque(mono_idx);
        drawn = 1'b1;
      end else if (d == rssd_pkg::OP_END) st = rssd_pkg::ST_END_SEEN;
      else step_x(d - rssd_pkg::OP_END);
    end else begin
      case (parse_st)
        WANT_LIT: begin
          len = 8'd1;
          argb = opaque(d);
          drawn = 1'b1;
          run_left = run_left - 8'd1;
          if (run_left == 8'd0) parse_st = WANT_OP;
        end
        WANT_SHD_SEL: begin
          if (d[1:0] != 2'd0) begin
            len = {6'd0, d[1:0]};
            argb = rssd_pkg::SHADOW_ARGB;
            drawn = 1'b1;
            parse_st = WANT_OP;
          end else begin
            parse_st = WANT_SHD_LEN;
          end
        end
        WANT_SHD_LEN: begin
          len = d;
          argb = rssd_pkg::SHADOW_ARGB;
          drawn = 1'b1;
          parse_st = WANT_OP;
        end
        WANT_REP_CNT: begin
          run_left = d;
          parse_st = WANT_REP_IDX;
        end
        WANT_REP_IDX: begin
          len = run_left;
          argb = opaque(d);
          drawn = 1'b1;
          run_left = '0;
          parse_st = WANT_OP;
        end
        default: begin
          parse_st = WANT_OP;
          if (d == rssd_pkg::OP_NEW_ROW) next_row();
          else if (d < rssd_pkg::OP_END) begin
            run_left = d;
            parse_st = WANT_LIT;
          end else if (d == rssd_pkg::OP_END) st = rssd_pkg::ST_END_SEEN;
          else if (d < rssd_pkg::OP_SHADOW) step_x(d - rssd_pkg::OP_END);
          else if (d == rssd_pkg::OP_SHADOW) parse_st = WANT_SHD_SEL;
          else if (d == rssd_pkg::OP_REPEAT) parse_st = WANT_REP_CNT;
          else begin
            run_left = d - rssd_pkg::OP_SHADOW;
            parse_st = WANT_REP_IDX;
          end
        end
      endcase
    end
    // zero-length runs draw nothing
    if (drawn && len == 8'd0) drawn = 1'b0;
    if (!drawn) begin
      len = '0;
      argb = '0;
    end
    span.span_x = 16'(cur_x);
    span.span_row = 16'(cur_y);
    span.span_len = len;
    span.pixel_argb = argb;
    if (drawn) step_x(len);
    if (st == rssd_pkg::ST_END_SEEN) begin
      if (beat.last_byte) restart_sprite();
      else ended = 1'b1;
    end else if (beat.last_byte) begin
      st = rssd_pkg::ST_RAN_OUT;
      restart_sprite();
    end else if (!drawn) begin
      return 1'b0;
    end
    span.status = st;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // beat builders and the sender
  // ---------------------------------------------------------------------
  function automatic rssd_pkg::in_beat_t data_beat(input logic [7:0] d, input logic last);
    rssd_pkg::in_beat_t beat;
    beat.req_type = 1'b0;
    beat.data_byte = d;
    beat.last_byte = last;
    beat.pal_index = 8'($urandom());    // don't-care fields still toggle
    beat.pal_rgb = 24'($urandom());
    return beat;
  endfunction

  function automatic rssd_pkg::in_beat_t pal_beat(input logic [7:0] idx,
                                                  input logic [23:0] rgb);
    rssd_pkg::in_beat_t beat;
    beat.req_type = 1'b1;
    beat.data_byte = 8'($urandom());
    beat.last_byte = 1'($urandom());
    beat.pal_index = idx;
    beat.pal_rgb = rgb;
    return beat;
  endfunction

  // one beat; valid stays up between back-to-back beats of a burst
  task automatic send_beat(input rssd_pkg::in_beat_t beat);
    int unsigned gap;
    rssd_pkg::out_beat_t span;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge
    if (beat.req_type) pal_writes++;
    else data_beats++;
    if (beat.req_type || !ended) live_beats++;
    if (predict_span(beat, span)) pending_spans.insert(pending_spans.size(), span);
  endtask

  task automatic send_seq(input byte_seq_t seq, input bit cut);
    for (int i = 0; i < seq.size(); i++)
      send_beat(data_beat(seq[i], cut && (i == seq.size() - 1)));
  endtask

  // random byte traffic: now and then a palette write slips in, or the data runs out
  task automatic send_coded(input logic [7:0] d);
    if ($urandom_range(0, 99) < 5) send_beat(pal_beat(8'($urandom()), 24'($urandom())));
    send_beat(data_beat(d, $urandom_range(0, 99) < 2));
  endtask

  // stop sending, let every result arrive and the pipeline empty
  task automatic drain_pipeline();
    if (in_valid) in_valid <= 1'b0;
    burst_left = 0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] val);
    drain_pipeline();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    if (idx == rssd_pkg::CFG_DECODE_MODE) mono_mode = val[0];
    else mono_idx = val;
  endtask

  // ---------------------------------------------------------------------
  // receiver: the stall pattern switches at random among four styles
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_style <= $urandom_range(0, 3);
      ready_left <= $urandom_range(32, 200);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (ready_left % 8 < 3);
    endcase
  end

  // ---------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------
  function automatic void log_failure(input string what, input rssd_pkg::out_beat_t want,
                                      input rssd_pkg::out_beat_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s: expected x=%0d row=%0d len=%0d argb=%h st=%0d",
               what, want.span_x, want.span_row, want.span_len, want.pixel_argb,
               want.status);
      $display("  got x=%0d row=%0d len=%0d argb=%h st=%0d",
               got.span_x, got.span_row, got.span_len, got.pixel_argb, got.status);
    end
  endfunction

  always @(posedge clk) begin : check_results
    rssd_pkg::out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (out_data.span_len != 8'd0) spans_seen++;
      if (out_data.status == rssd_pkg::ST_END_SEEN) ends_seen++;
      if (out_data.status == rssd_pkg::ST_RAN_OUT) ranout_seen++;
      if (pending_spans.size() == 0) begin
        log_failure("unexpected result", '0, out_data);
      end else begin
        want = pending_spans.pop_front();
        if (out_data.span_x !== want.span_x || out_data.span_row !== want.span_row ||
            out_data.span_len !== want.span_len || out_data.pixel_argb !== want.pixel_argb ||
            out_data.status !== want.status)
          log_failure("result mismatch", want, out_data);
      end
    end
  end

  // watchdog: no beat on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_spans.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // every entry gets written before any color lookup can happen
  task automatic test_palette_load();
    logic [23:0] rgb;
    for (int i = 0; i < rssd_pkg::PALETTE_DEPTH; i++) begin
      rgb = (i == 0) ? 24'h000000 :
            (i == rssd_pkg::PALETTE_DEPTH - 1) ? 24'hFFFFFF : 24'($urandom());
      send_beat(pal_beat(8'(i), rgb));
    end
  endtask

  // each full-mode opcode at least once, plus the extremes of its operands
  task automatic test_full_opcodes();
    send_seq('{8'h00,                    // new row
               8'h02, 8'h00, 8'hFF,      // two literals, lowest and highest index
               8'hBF, 8'h81,             // longest and shortest skip
               8'hC0, 8'hC3,             // shadow, length in the selector
               8'hC0, 8'h04, 8'hFF,      // shadow, length in the next byte
               8'hC0, 8'h08, 8'h00,      // shadow of length zero, no span
               8'hC1, 8'hFF, 8'h12,      // counted repeat, full count
               8'hC1, 8'h00, 8'h34,      // counted repeat of zero, no span
               8'hFF, 8'h56, 8'hC2, 8'h78, // short repeats, longest and shortest
               rssd_pkg::OP_END, 8'h11, 8'h22}, // end marker, trailing bytes dropped
             1'b1);
  endtask

  // data running out at every kind of point
  task automatic test_last_byte();
    send_seq('{8'h01, 8'h05}, 1'b1);                  // last byte that also draws
    send_seq('{rssd_pkg::OP_REPEAT, 8'h10}, 1'b1);    // cut inside a counted repeat
    send_seq('{8'hBF, rssd_pkg::OP_NEW_ROW, 8'h85}, 1'b1);
    send_seq('{rssd_pkg::OP_END}, 1'b1);              // end marker on the last byte
    send_seq('{rssd_pkg::OP_END, 8'h03, rssd_pkg::OP_END, 8'h00}, 1'b1);
    send_seq('{rssd_pkg::OP_SHADOW, 8'h00, 8'h00}, 1'b1); // empty shadow, then out of data
  endtask

  // register changes while the parser sits inside an instruction
  task automatic test_mode_switch();
    send_seq('{8'hC2}, 1'b0);                // short repeat waiting for its index
    write_cfg(rssd_pkg::CFG_DECODE_MODE, 8'd1);
    write_cfg(rssd_pkg::CFG_MONO_COLOR, 8'hFF);
    send_seq('{8'h03, 8'h81, rssd_pkg::OP_NEW_ROW, 8'h7F}, 1'b0);
    write_cfg(rssd_pkg::CFG_MONO_COLOR, 8'h00);
    send_seq('{8'h01, 8'hFF}, 1'b0);
    write_cfg(rssd_pkg::CFG_DECODE_MODE, 8'd0);
    send_seq('{8'h05, 8'h10, 8'h20}, 1'b0);  // literal run left half done
    write_cfg(rssd_pkg::CFG_DECODE_MODE, 8'd1);
    send_seq('{8'h02}, 1'b0);                // read as a mono run
    write_cfg(rssd_pkg::CFG_DECODE_MODE, 8'd0);
    send_seq('{8'hC3, 8'h44, rssd_pkg::OP_END, 8'hAA}, 1'b1);
  endtask

  // one well-formed instruction for the current mode, now and then noise
  task automatic send_instr();
    int unsigned pick;
    int unsigned n;
    logic [7:0] sel;
    pick = $urandom_range(0, 99);
    if (mono_mode) begin
      if (pick < 15) send_coded(rssd_pkg::OP_NEW_ROW);
      else if (pick < 60) send_coded(8'($urandom_range(1, 127)));
      else if (pick < 95) send_coded(8'($urandom_range(129, 255)));
      else send_coded(8'($urandom()));
    end else if (pick < 10) begin
      send_coded(rssd_pkg::OP_NEW_ROW);
    end else if (pick < 30) begin
      // mostly short literal runs, a few long ones
      n = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 4);
      send_coded(8'(n));
      repeat (n) send_coded(8'($urandom()));
    end else if (pick < 42) begin
      send_coded(8'($urandom_range(129, 191)));
    end else if (pick < 55) begin
      sel = 8'($urandom());
      send_coded(rssd_pkg::OP_SHADOW);
      send_coded(sel);
      if (sel[1:0] == 2'd0)
        send_coded(($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
    end else if (pick < 70) begin
      send_coded(rssd_pkg::OP_REPEAT);
      send_coded(($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
      send_coded(8'($urandom()));
    end else if (pick < 92) begin
      send_coded(8'($urandom_range(194, 255)));
      send_coded(8'($urandom()));
    end else begin
      send_coded(8'($urandom()));
    end
  endtask

  task automatic send_sprite();
    repeat ($urandom_range(2, 12)) send_instr();
    case ($urandom_range(0, 3))
      0: send_beat(data_beat(rssd_pkg::OP_END, 1'b1));
      1: begin
        // end marker, a few dropped bytes, then the last one
        send_beat(data_beat(rssd_pkg::OP_END, 1'b0));
        repeat ($urandom_range(0, 3)) send_beat(data_beat(8'($urandom()), 1'b0));
        send_beat(data_beat(8'($urandom()), 1'b1));
      end
      default: send_beat(data_beat(8'($urandom()), 1'b1));
    endcase
  endtask

  // random sprites over a series of register settings, extremes first
  task automatic test_random_streams();
    int unsigned goal;
    int unsigned phase;
    goal = live_beats + RANDOM_BEATS;
    phase = 0;
    while (live_beats < goal) begin
      case (phase)
        0: begin
          write_cfg(rssd_pkg::CFG_DECODE_MODE, 8'd0);
          write_cfg(rssd_pkg::CFG_MONO_COLOR, 8'h00);
        end
        1: begin
          write_cfg(rssd_pkg::CFG_DECODE_MODE, 8'd1);
          write_cfg(rssd_pkg::CFG_MONO_COLOR, 8'hFF);
        end
        2: write_cfg(rssd_pkg::CFG_MONO_COLOR, 8'h00);
        3: write_cfg(rssd_pkg::CFG_DECODE_MODE, 8'd0);
        default: begin
          write_cfg(rssd_pkg::CFG_DECODE_MODE, 8'($urandom_range(0, 1)));
          write_cfg(rssd_pkg::CFG_MONO_COLOR, 8'($urandom()));
        end
      endcase
      repeat ($urandom_range(2, 5)) send_sprite();
      // sometimes hold off until the decoder has caught up
      if ($urandom_range(0, 3) == 0) drain_pipeline();
      phase++;
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= rssd_pkg::CFG_DECODE_MODE;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_palette_load();
    test_full_opcodes();
    test_last_byte();
    test_mode_switch();
    test_random_streams();

    drain_pipeline();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d data beats and %0d palette writes across %0d register writes",
             data_beats, pal_writes, cfg_writes);
    $display("results: %0d spans, %0d end markers, %0d ran-out, %0d failures",
             spans_seen, ends_seen, ranout_seen, fail_count);
    if (fail_count == 0 && pending_spans.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rssd_pkg.sv
rtl/rle_sprite_span_decoder_top.sv
sim/tb_top.sv
